// ----- src/mteq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mteq_pkg
// Types and codes shared by the timer expiry queue modules.
// ----------------------------------------------------------------------------
package mteq_pkg;

	typedef struct packed {
		logic [2:0]         operation;
		logic [4:0]         timer_index;
		logic [7:0]         channel;
		logic signed [31:0] payload;
		logic [31:0]        delay;
		logic               system_owned;
	} mteq_in_t;

	typedef struct packed {
		logic               kind;
		logic [4:0]         entry;
		logic [7:0]         dest_channel;
		logic signed [31:0] message;
		logic               ok;
		logic               task_switch;
		logic               last;
	} mteq_out_t;

	// memory write strobes from the sequencer
	typedef struct packed {
		logic cfg_we;
		logic arm_we;
	} mteq_wr_t;

	localparam logic [2:0] OP_ALLOC  = 3'd0;
	localparam logic [2:0] OP_FREE   = 3'd1;
	localparam logic [2:0] OP_SETUP  = 3'd2;
	localparam logic [2:0] OP_ARM    = 3'd3;
	localparam logic [2:0] OP_CANCEL = 3'd4;
	localparam logic [2:0] OP_TICK   = 3'd5;
	localparam logic [2:0] OP_PURGE  = 3'd6;

	localparam logic [1:0] ST_FREE  = 2'd0;
	localparam logic [1:0] ST_ALLOC = 2'd1;
	localparam logic [1:0] ST_ARMED = 2'd2;

	localparam logic KIND_STATUS = 1'b0;
	localparam logic KIND_EXPIRY = 1'b1;

	localparam logic CFG_ENABLE = 1'b0;
	localparam logic CFG_INDEX  = 1'b1;

endpackage

// ----- src/mteq_store.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mteq_store
// Per-entry memories: setup data and arm data, one write and one read port.
// ----------------------------------------------------------------------------
module mteq_store #(
	parameter int IW = 5,
	parameter int CW = 8
) (
	input  logic                  clk,
	input  mteq_pkg::mteq_wr_t    wr,
	input  logic [IW-1:0]         wr_addr,
	input  logic [CW-1:0]         wr_chan,
	input  logic signed [31:0]    wr_payload,
	input  logic [31:0]           wr_deadline,
	input  logic [31:0]           wr_stamp,
	input  logic [IW-1:0]         rd_addr,
	output logic [CW-1:0]         rd_chan,
	output logic signed [31:0]    rd_payload,
	output logic [31:0]           rd_deadline,
	output logic [31:0]           rd_stamp
);
	import mteq_pkg::*;

	localparam int DEPTH = 2 ** IW;

	logic [CW+31:0] cfg_mem [DEPTH];
	logic [63:0]    arm_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr.cfg_we) begin
			cfg_mem[wr_addr] <= {wr_chan, wr_payload};
		end
		{rd_chan, rd_payload} <= cfg_mem[rd_addr];
	end

	always_ff @(posedge clk) begin
		if (wr.arm_we) begin
			arm_mem[wr_addr] <= {wr_deadline, wr_stamp};
		end
		{rd_deadline, rd_stamp} <= arm_mem[rd_addr];
	end

endmodule

// ----- src/mteq_order.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mteq_order
// Compare unit: does a candidate fire before the current best.
// ----------------------------------------------------------------------------
module mteq_order (
	input  logic [31:0] seq,
	input  logic [31:0] cand_deadline,
	input  logic [31:0] cand_stamp,
	input  logic [31:0] best_deadline,
	input  logic [31:0] best_age,
	output logic [31:0] cand_age,
	output logic        cand_first
);
	// age is distance back from the arm counter, smaller is more recent
	assign cand_age = seq - cand_stamp;

	always_comb begin
		if (cand_deadline != best_deadline) begin
			cand_first = cand_deadline < best_deadline;
		end else begin
			cand_first = cand_age < best_age;
		end
	end

endmodule

// ----- src/multi_timer_expiry_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_timer_expiry_queue
// Pool of software timers on one tick count, firing in deadline order.
// ----------------------------------------------------------------------------
//  channel | signals                                  | transfer when
//  --------+------------------------------------------+----------------------
//  in      | in_valid, in_stall, in_item              | valid and not stall
//  out     | out_valid, out_stall, out_item           | valid and not stall
//  cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data| valid and ready
//
//  free, setup, arm, cancel and unused codes go from decode straight to status
//  allocate is a linear search of entry status for the lowest free entry
//  cancel all makes one memory read per entry
//  tick makes one pass of the compare unit over the memory for each entry that
//  fires and one more that finds none; each pass picks the next entry to fire
//  out stalls hold the sequencer on the pending result; no clearing pass
//  after reset, entry status flops clear at once
// ----------------------------------------------------------------------------
module multi_timer_expiry_queue #(
	parameter int NUM_TIMERS   = 32,
	parameter int CHANNEL_BITS = 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  mteq_pkg::mteq_in_t  in_item,
	output logic                out_valid,
	input  logic                out_stall,
	output mteq_pkg::mteq_out_t out_item,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic                cfg_index,
	input  logic [4:0]          cfg_data
);
	import mteq_pkg::*;

	localparam int IW   = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int CNTW = $clog2(NUM_TIMERS + 1);
	localparam int CW   = (CHANNEL_BITS < 8) ? CHANNEL_BITS : 8;

	// sequencer states
	localparam logic [3:0] S_IDLE     = 4'd0;
	localparam logic [3:0] S_DECODE   = 4'd1;
	localparam logic [3:0] S_ALLOC    = 4'd2;
	localparam logic [3:0] S_PURGE_RD = 4'd3;
	localparam logic [3:0] S_PURGE_CK = 4'd4;
	localparam logic [3:0] S_SCAN_RD  = 4'd5;
	localparam logic [3:0] S_SCAN_CK  = 4'd6;
	localparam logic [3:0] S_FIRE     = 4'd7;
	localparam logic [3:0] S_STATUS   = 4'd8;

	logic [3:0]      state_q;
	mteq_in_t        item_q;
	logic [CNTW-1:0] cnt_q;
	logic [31:0]     tick_q;
	logic [31:0]     seq_q;
	logic [1:0]      status_q [NUM_TIMERS];
	logic            sys_q    [NUM_TIMERS];
	logic            ok_q;
	logic [IW-1:0]   ent_q;
	logic            ts_q;
	logic            found_q;
	logic [IW-1:0]   best_idx_q;
	logic [31:0]     best_dl_q;
	logic [31:0]     best_age_q;
	logic [CW-1:0]   best_chan_q;
	logic [31:0]     best_pay_q;
	logic            tt_en_q;
	logic [4:0]      tt_idx_q;
	logic            out_valid_q;
	mteq_out_t       out_q;

	// memory side
	mteq_wr_t        wr;
	logic [IW-1:0]   cnt_idx;
	logic [IW-1:0]   op_idx;
	logic            op_idx_ok;
	logic [CW-1:0]   op_chan;
	logic [CW-1:0]   rd_chan;
	logic [31:0]     rd_payload;
	logic [31:0]     rd_deadline;
	logic [31:0]     rd_stamp;
	logic [31:0]     cand_age;
	logic            cand_first;
	logic            scan_end;
	logic            slot_free;
	logic            is_task;
	logic            out_load;

	assign cnt_idx   = cnt_q[IW-1:0];
	assign op_idx    = IW'(item_q.timer_index);
	assign op_idx_ok = 32'(item_q.timer_index) < NUM_TIMERS;
	assign op_chan   = CW'(item_q.channel);
	assign scan_end  = cnt_q == CNTW'(NUM_TIMERS);
	// output register empties this cycle or already is empty
	assign slot_free = !out_valid_q || !out_stall;
	assign is_task   = tt_en_q && (32'(best_idx_q) == 32'(tt_idx_q));
	// a new result enters the output register this cycle
	assign out_load  = slot_free &&
	                   ((state_q == S_FIRE && !is_task) || state_q == S_STATUS);

	assign in_stall  = state_q != S_IDLE;
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// setup writes channel and payload, arm writes deadline and stamp
	always_comb begin
		wr.cfg_we = 1'b0;
		wr.arm_we = 1'b0;
		if (state_q == S_DECODE && op_idx_ok && status_q[op_idx] != ST_FREE) begin
			wr.cfg_we = item_q.operation == OP_SETUP;
			wr.arm_we = item_q.operation == OP_ARM;
		end
	end

	mteq_store #(
		.IW (IW),
		.CW (CW)
	) u_store (
		.clk         (clk),
		.wr          (wr),
		.wr_addr     (op_idx),
		.wr_chan     (op_chan),
		.wr_payload  (item_q.payload),
		.wr_deadline (item_q.delay + tick_q),
		.wr_stamp    (seq_q + 32'd1),
		.rd_addr     (cnt_idx),
		.rd_chan     (rd_chan),
		.rd_payload  (rd_payload),
		.rd_deadline (rd_deadline),
		.rd_stamp    (rd_stamp)
	);

	mteq_order u_order (
		.seq           (seq_q),
		.cand_deadline (rd_deadline),
		.cand_stamp    (rd_stamp),
		.best_deadline (best_dl_q),
		.best_age      (best_age_q),
		.cand_age      (cand_age),
		.cand_first    (cand_first)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			item_q      <= '0;
			cnt_q       <= '0;
			tick_q      <= '0;
			seq_q       <= '0;
			ok_q        <= 1'b0;
			ent_q       <= '0;
			ts_q        <= 1'b0;
			found_q     <= 1'b0;
			best_idx_q  <= '0;
			best_dl_q   <= '0;
			best_age_q  <= '0;
			best_chan_q <= '0;
			best_pay_q  <= '0;
			tt_en_q     <= 1'b0;
			tt_idx_q    <= '0;
			out_valid_q <= 1'b0;
			out_q       <= '0;
			for (int i = 0; i < NUM_TIMERS; i++) begin
				status_q[i] <= ST_FREE;
				sys_q[i]    <= 1'b0;
			end
		end else begin
			// configuration, to be written by the user only while idle; the block does not enforce it
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_ENABLE: tt_en_q  <= cfg_data[0];
					CFG_INDEX:  tt_idx_q <= cfg_data;
					default:    ;
				endcase
			end

			if (out_valid_q && !out_stall && !out_load) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q  <= in_item;
						ok_q    <= 1'b0;
						ent_q   <= '0;
						ts_q    <= 1'b0;
						cnt_q   <= '0;
						found_q <= 1'b0;
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					unique case (item_q.operation)
						OP_ALLOC: state_q <= S_ALLOC;
						OP_TICK:  state_q <= S_SCAN_RD;
						OP_PURGE: state_q <= S_PURGE_RD;
						default:  state_q <= S_STATUS;
					endcase
					unique case (item_q.operation)
						OP_FREE: begin
							if (op_idx_ok) begin
								status_q[op_idx] <= ST_FREE;
							end
						end
						OP_SETUP: begin
							if (op_idx_ok && status_q[op_idx] != ST_FREE) begin
								sys_q[op_idx] <= item_q.system_owned;
							end
						end
						OP_ARM: begin
							if (op_idx_ok && status_q[op_idx] != ST_FREE) begin
								seq_q            <= seq_q + 32'd1;
								status_q[op_idx] <= ST_ARMED;
							end
						end
						OP_CANCEL: begin
							if (op_idx_ok && status_q[op_idx] == ST_ARMED) begin
								status_q[op_idx] <= ST_ALLOC;
								ok_q             <= 1'b1;
							end
						end
						OP_TICK: tick_q <= tick_q + 32'd1;
						default: ;
					endcase
				end
				// lowest free entry, one entry a cycle
				S_ALLOC: begin
					if (scan_end) begin
						state_q <= S_STATUS;
					end else if (status_q[cnt_idx] == ST_FREE) begin
						status_q[cnt_idx] <= ST_ALLOC;
						sys_q[cnt_idx]    <= 1'b1;
						ok_q              <= 1'b1;
						ent_q             <= cnt_idx;
						state_q           <= S_STATUS;
					end else begin
						cnt_q <= cnt_q + CNTW'(1);
					end
				end
				// memory read issued here, data checked next cycle
				S_PURGE_RD: begin
					state_q <= scan_end ? S_STATUS : S_PURGE_CK;
				end
				S_PURGE_CK: begin
					if (status_q[cnt_idx] != ST_FREE && !sys_q[cnt_idx] &&
					    rd_chan == op_chan) begin
						status_q[cnt_idx] <= ST_FREE;
					end
					cnt_q   <= cnt_q + CNTW'(1);
					state_q <= S_PURGE_RD;
				end
				// one pass finds the next entry due to fire
				S_SCAN_RD: begin
					if (scan_end) begin
						state_q <= found_q ? S_FIRE : S_STATUS;
					end else begin
						state_q <= S_SCAN_CK;
					end
				end
				S_SCAN_CK: begin
					if (status_q[cnt_idx] == ST_ARMED && rd_deadline <= tick_q &&
					    (!found_q || cand_first)) begin
						found_q     <= 1'b1;
						best_idx_q  <= cnt_idx;
						best_dl_q   <= rd_deadline;
						best_age_q  <= cand_age;
						best_chan_q <= rd_chan;
						best_pay_q  <= rd_payload;
					end
					cnt_q   <= cnt_q + CNTW'(1);
					state_q <= S_SCAN_RD;
				end
				S_FIRE: begin
					if (is_task || slot_free) begin
						status_q[best_idx_q] <= ST_ALLOC;
						cnt_q                <= '0;
						found_q              <= 1'b0;
						state_q              <= S_SCAN_RD;
						if (is_task) begin
							ts_q <= 1'b1;
						end else begin
							out_valid_q        <= 1'b1;
							out_q.kind         <= KIND_EXPIRY;
							out_q.entry        <= 5'(best_idx_q);
							out_q.dest_channel <= 8'(best_chan_q);
							out_q.message      <= best_pay_q;
							out_q.ok           <= 1'b0;
							out_q.task_switch  <= 1'b0;
							out_q.last         <= 1'b0;
						end
					end
				end
				S_STATUS: begin
					if (slot_free) begin
						out_valid_q        <= 1'b1;
						out_q.kind         <= KIND_STATUS;
						out_q.entry        <= 5'(ent_q);
						out_q.dest_channel <= '0;
						out_q.message      <= '0;
						out_q.ok           <= ok_q;
						out_q.task_switch  <= ts_q;
						out_q.last         <= 1'b1;
						state_q            <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
